### rtl/fjp_pkg.sv
// ----------------------------------------------------------------------------
// fjp_pkg: shared definitions for the four-joint first-order plant
// Mode codes, register widths and reset values, fixed-point constants and
// the command word that the controller hands to every joint lane.
// ----------------------------------------------------------------------------
package fjp_pkg;

  localparam int JOINT_COUNT_DEF = 4;
  localparam int VALUE_WIDTH_DEF = 32;

  localparam int FUNC_W     = 2;
  localparam int GAIN_W     = 17;
  localparam int STEP_W     = 25;
  localparam int INV_W      = 32;
  localparam int CFG_DATA_W = 32;

  // Binary point of the Q16.16 values and of the gains.
  localparam int FRAC_BITS  = 16;
  // The step is in units of 2^-24 s and the trapezoid halves the sum.
  localparam int STEP_SHIFT = 25;

  localparam logic [FUNC_W-1:0] FUNC_VEL  = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_POS  = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_LOAD = 2'd2;

  localparam logic [GAIN_W-1:0] GAIN_ONE     = 17'h10000;
  localparam logic [STEP_W-1:0] STEP_RST_VAL = 25'd16777;
  localparam logic [INV_W-1:0]  INV_RST_VAL  = 32'd65536000;

  typedef struct packed {
    logic start;     // a word has been taken
    logic run;       // integrate one step
    logic load;      // load positions, clear velocities
    logic pos_mode;  // position target rather than velocity command
  } lane_cmd_t;

endpackage

### rtl/fjp_lane.sv
// ----------------------------------------------------------------------------
// fjp_lane: one joint of the plant
// Holds the joint's position and velocity and steps them with a single
// shared multiplier: gain product, first update, then the low and high
// halves of the step or inverse-step product, then the final rounding and
// saturation.
// ----------------------------------------------------------------------------
module fjp_lane #(
  parameter int VALUE_WIDTH = fjp_pkg::VALUE_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  fjp_pkg::lane_cmd_t            cmd_i,
  input  logic [VALUE_WIDTH-1:0]        value_i,
  input  logic [fjp_pkg::GAIN_W-1:0]    gain_i,
  input  logic [fjp_pkg::STEP_W-1:0]    step_time_i,
  input  logic [fjp_pkg::INV_W-1:0]     inv_step_i,
  output logic [VALUE_WIDTH-1:0]        pos_o,
  output logic [VALUE_WIDTH-1:0]        vel_o,
  output logic                          done_o
);
  import fjp_pkg::*;

  localparam int XW = VALUE_WIDTH + 1;           // difference or sum of two values
  localparam int MW = GAIN_W + 1;                // multiplier operand, signed
  localparam int PW = XW + MW;
  localparam int AW = VALUE_WIDTH + INV_W + 2;   // full product plus rounding
  localparam int HW = INV_W / 2;
  localparam int SW = AW + 1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MULA,
    ST_UPD,
    ST_MULLO,
    ST_MULHI,
    ST_FIN
  } step_t;

  step_t                   step_r, step_nxt;
  logic                    pos_mode_r, pos_mode_nxt;
  logic                    done_r, done_nxt;
  logic [VALUE_WIDTH-1:0]  pos_r, pos_nxt;
  logic [VALUE_WIDTH-1:0]  vel_r, vel_nxt;
  logic signed [XW-1:0]    x_r, x_nxt;
  logic signed [AW-1:0]    acc_r, acc_nxt;

  logic [GAIN_W-1:0]       alpha;
  logic [INV_W-1:0]        m2;
  logic [GAIN_W-1:0]       mul_op;
  logic signed [PW-1:0]    prod;
  logic [AW-1:0]           prod_ext;
  logic [AW-1:0]           half_b;
  logic signed [AW-1:0]    acc_q16;
  logic signed [AW-1:0]    acc_q25;
  logic [VALUE_WIDTH-1:0]  base1;
  logic [SW-1:0]           sum1;
  logic [VALUE_WIDTH-1:0]  first;
  logic [XW-1:0]           x_upd;
  logic [XW-1:0]           x_start;
  logic [VALUE_WIDTH-1:0]  start_base;
  logic [VALUE_WIDTH-1:0]  fin_base;
  logic [AW-1:0]           fin_sh;
  logic [SW-1:0]           sum2;
  logic [VALUE_WIDTH-1:0]  second;

  function automatic logic [VALUE_WIDTH-1:0] sat_fn(input logic [SW-1:0] x);
    logic all_ones;
    logic all_zeros;
    all_ones  = &x[SW-1:VALUE_WIDTH-1];
    all_zeros = ~|x[SW-1:VALUE_WIDTH-1];
    if (all_ones || all_zeros) begin
      return x[VALUE_WIDTH-1:0];
    end else if (x[SW-1]) begin
      return {1'b1, {(VALUE_WIDTH-1){1'b0}}};
    end else begin
      return {1'b0, {(VALUE_WIDTH-1){1'b1}}};
    end
  endfunction

  always_comb begin
    alpha = (gain_i > GAIN_ONE) ? GAIN_ONE : gain_i;
    m2    = pos_mode_r ? inv_step_i : INV_W'(step_time_i);
    case (step_r)
      ST_MULLO: mul_op = GAIN_W'(m2[HW-1:0]);
      ST_MULHI: mul_op = GAIN_W'(m2[INV_W-1:HW]);
      default:  mul_op = alpha;
    endcase
    prod     = x_r * $signed({1'b0, mul_op});
    prod_ext = {{(AW-PW){prod[PW-1]}}, prod};
    half_b   = pos_mode_r ? (AW'(1) << (FRAC_BITS - 1)) : (AW'(1) << (STEP_SHIFT - 1));
    acc_q16  = acc_r >>> FRAC_BITS;
    acc_q25  = acc_r >>> STEP_SHIFT;

    // First update: the joint quantity that relaxes toward the input.
    base1 = pos_mode_r ? pos_r : vel_r;
    sum1  = {{(SW-VALUE_WIDTH){base1[VALUE_WIDTH-1]}}, base1} + {acc_q16[AW-1], acc_q16};
    first = sat_fn(sum1);
    if (pos_mode_r) begin
      x_upd = {first[VALUE_WIDTH-1], first} - {pos_r[VALUE_WIDTH-1], pos_r};
    end else begin
      x_upd = {vel_r[VALUE_WIDTH-1], vel_r} + {first[VALUE_WIDTH-1], first};
    end

    // Second update: position from the trapezoid, or velocity from the change.
    fin_base = pos_mode_r ? '0 : pos_r;
    fin_sh   = pos_mode_r ? acc_q16 : acc_q25;
    sum2     = {{(SW-VALUE_WIDTH){fin_base[VALUE_WIDTH-1]}}, fin_base} + {fin_sh[AW-1], fin_sh};
    second   = sat_fn(sum2);

    start_base = cmd_i.pos_mode ? pos_r : vel_r;
    x_start    = {value_i[VALUE_WIDTH-1], value_i} - {start_base[VALUE_WIDTH-1], start_base};
  end

  always_comb begin
    step_nxt     = step_r;
    pos_mode_nxt = pos_mode_r;
    done_nxt     = 1'b0;
    pos_nxt      = pos_r;
    vel_nxt      = vel_r;
    x_nxt        = x_r;
    acc_nxt      = acc_r;
    case (step_r)
      ST_IDLE: begin
        if (cmd_i.start) begin
          if (cmd_i.run) begin
            step_nxt     = ST_MULA;
            pos_mode_nxt = cmd_i.pos_mode;
            x_nxt        = x_start;
          end else begin
            if (cmd_i.load) begin
              pos_nxt = value_i;
              vel_nxt = '0;
            end
            done_nxt = 1'b1;
          end
        end
      end
      ST_MULA: begin
        acc_nxt  = prod_ext + (AW'(1) << (FRAC_BITS - 1));
        step_nxt = ST_UPD;
      end
      ST_UPD: begin
        if (pos_mode_r) begin
          pos_nxt = first;
        end else begin
          vel_nxt = first;
        end
        x_nxt    = x_upd;
        step_nxt = ST_MULLO;
      end
      ST_MULLO: begin
        acc_nxt  = prod_ext + half_b;
        step_nxt = ST_MULHI;
      end
      ST_MULHI: begin
        acc_nxt  = acc_r + (prod_ext << HW);
        step_nxt = ST_FIN;
      end
      ST_FIN: begin
        if (pos_mode_r) begin
          vel_nxt = second;
        end else begin
          pos_nxt = second;
        end
        done_nxt = 1'b1;
        step_nxt = ST_IDLE;
      end
      default: begin
        step_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= ST_IDLE;
      done_r <= 1'b0;
      pos_r  <= '0;
      vel_r  <= '0;
    end else begin
      step_r     <= step_nxt;
      done_r     <= done_nxt;
      pos_r      <= pos_nxt;
      vel_r      <= vel_nxt;
      pos_mode_r <= pos_mode_nxt;
      x_r        <= x_nxt;
      acc_r      <= acc_nxt;
    end
  end

  assign pos_o  = pos_r;
  assign vel_o  = vel_r;
  assign done_o = done_r;

endmodule

### rtl/fjp_merge.sv
// ----------------------------------------------------------------------------
// fjp_merge: result register
// Gathers the positions and velocities of all lanes into one output word
// and holds it until the receiver takes it.
// ----------------------------------------------------------------------------
module fjp_merge #(
  parameter int JOINT_COUNT = fjp_pkg::JOINT_COUNT_DEF,
  parameter int VALUE_WIDTH = fjp_pkg::VALUE_WIDTH_DEF
) (
  input  logic                                            clk,
  input  logic                                            rst_n,
  input  logic                                            capture_i,
  input  logic [JOINT_COUNT-1:0][VALUE_WIDTH-1:0]         pos_i,
  input  logic [JOINT_COUNT-1:0][VALUE_WIDTH-1:0]         vel_i,
  input  logic                                            out_tready,
  output logic                                            out_tvalid,
  output logic [((2*JOINT_COUNT*VALUE_WIDTH+7)/8)*8-1:0]  out_tdata
);
  import fjp_pkg::*;

  localparam int OUT_W = ((2 * JOINT_COUNT * VALUE_WIDTH + 7) / 8) * 8;

  logic             tvalid_r;
  logic [OUT_W-1:0] tdata_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tvalid_r <= 1'b0;
    end else if (capture_i) begin
      tvalid_r <= 1'b1;
    end else if (out_tready) begin
      tvalid_r <= 1'b0;
    end
  end

  // Positions in the low half, velocities above, padding zero.
  always_ff @(posedge clk) begin
    if (capture_i) begin
      tdata_r <= OUT_W'({vel_i, pos_i});
    end
  end

  assign out_tvalid = tvalid_r;
  assign out_tdata  = tdata_r;

endmodule

### rtl/four_joint_first_order_plant.sv
// ----------------------------------------------------------------------------
// four_joint_first_order_plant: first-order joint plant with trapezoidal step
//
// Each input word on in_* carries a mode in in_tuser and one signed Q16.16
// value per joint in in_tdata. Velocity mode relaxes each velocity toward
// its command and advances the position by the trapezoid of old and new
// velocity; position mode relaxes each position toward its target and sets
// the velocity from the change; load mode sets positions and clears
// velocities. Every word returns one word on out_*: all positions, then all
// velocities, saturated.
// Joints run in parallel lanes, each with one multiplier that is used three
// times per step. A step word passes through the lane states for the gain
// product, the first update, the low and high products and the final
// update; a load word, an unused mode or a step with a zero step time skips
// them. The next word is taken only once the previous result is captured.
// The output register frees the input side: in_tready returns while an
// earlier result still waits, and a stalled receiver only holds the block
// once a newer result is ready. Reset clears the joint state and loads the
// gains with 1.0, the step with 16777 and the inverse step with 65536000.
// Write registers through cfg_* only while no word is in flight; the block does not enforce it.
// ----------------------------------------------------------------------------
module four_joint_first_order_plant #(
  parameter int JOINT_COUNT = fjp_pkg::JOINT_COUNT_DEF,
  parameter int VALUE_WIDTH = fjp_pkg::VALUE_WIDTH_DEF
) (
  input  logic                                            clk,
  input  logic                                            rst_n,
  input  logic                                            in_tvalid,
  output logic                                            in_tready,
  // value_joint0 .. value_joint(N-1), lowest bits first
  input  logic [((JOINT_COUNT*VALUE_WIDTH+7)/8)*8-1:0]    in_tdata,
  // func
  input  logic [fjp_pkg::FUNC_W-1:0]                      in_tuser,
  output logic                                            out_tvalid,
  input  logic                                            out_tready,
  // pos_joint0 .. pos_joint(N-1), then vel_joint0 .. vel_joint(N-1)
  output logic [((2*JOINT_COUNT*VALUE_WIDTH+7)/8)*8-1:0]  out_tdata,
  input  logic                                            cfg_we,
  input  logic [$clog2(JOINT_COUNT+2)-1:0]                cfg_addr,
  input  logic [fjp_pkg::CFG_DATA_W-1:0]                  cfg_wdata
);
  import fjp_pkg::*;

  localparam int CFG_AW = $clog2(JOINT_COUNT + 2);

  typedef enum logic [1:0] {
    S_IDLE,
    S_RUN,
    S_HOLD
  } state_t;

  state_t                                   state_r, state_nxt;
  logic [GAIN_W-1:0]                        gain_r [JOINT_COUNT];
  logic [STEP_W-1:0]                        step_time_r;
  logic [INV_W-1:0]                         inv_step_r;
  logic                                     accept;
  logic                                     capture;
  logic                                     out_free;
  logic                                     all_done;
  lane_cmd_t                                cmd;
  logic [JOINT_COUNT-1:0]                   lane_done;
  logic [JOINT_COUNT-1:0][VALUE_WIDTH-1:0]  lane_pos;
  logic [JOINT_COUNT-1:0][VALUE_WIDTH-1:0]  lane_vel;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int j = 0; j < JOINT_COUNT; j++) begin
        gain_r[j] <= GAIN_ONE;
      end
      step_time_r <= STEP_RST_VAL;
      inv_step_r  <= INV_RST_VAL;
    end else if (cfg_we) begin
      for (int j = 0; j < JOINT_COUNT; j++) begin
        if (cfg_addr == CFG_AW'(j)) begin
          gain_r[j] <= cfg_wdata[GAIN_W-1:0];
        end
      end
      if (cfg_addr == CFG_AW'(JOINT_COUNT)) begin
        step_time_r <= cfg_wdata[STEP_W-1:0];
      end
      if (cfg_addr == CFG_AW'(JOINT_COUNT + 1)) begin
        inv_step_r <= cfg_wdata[INV_W-1:0];
      end
    end
  end

  assign in_tready = (state_r == S_IDLE);
  assign accept    = in_tvalid && in_tready;
  assign out_free  = !out_tvalid || out_tready;
  assign all_done  = &lane_done;

  // A zero step time turns both integrating modes into a plain read-back.
  always_comb begin
    cmd       = '0;
    cmd.start = accept;
    case (in_tuser)
      FUNC_VEL: begin
        cmd.run = (step_time_r != '0);
      end
      FUNC_POS: begin
        cmd.run      = (step_time_r != '0);
        cmd.pos_mode = 1'b1;
      end
      FUNC_LOAD: begin
        cmd.load = 1'b1;
      end
      default: begin
        cmd.run = 1'b0;
      end
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    capture   = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          state_nxt = S_RUN;
        end
      end
      S_RUN: begin
        if (all_done) begin
          if (out_free) begin
            capture   = 1'b1;
            state_nxt = S_IDLE;
          end else begin
            state_nxt = S_HOLD;
          end
        end
      end
      S_HOLD: begin
        if (out_free) begin
          capture   = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  for (genvar j = 0; j < JOINT_COUNT; j++) begin : g_lane
    fjp_lane #(
      .VALUE_WIDTH (VALUE_WIDTH)
    ) u_lane (
      .clk         (clk),
      .rst_n       (rst_n),
      .cmd_i       (cmd),
      .value_i     (in_tdata[j*VALUE_WIDTH +: VALUE_WIDTH]),
      .gain_i      (gain_r[j]),
      .step_time_i (step_time_r),
      .inv_step_i  (inv_step_r),
      .pos_o       (lane_pos[j]),
      .vel_o       (lane_vel[j]),
      .done_o      (lane_done[j])
    );
  end

  fjp_merge #(
    .JOINT_COUNT (JOINT_COUNT),
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_merge (
    .clk        (clk),
    .rst_n      (rst_n),
    .capture_i  (capture),
    .pos_i      (lane_pos),
    .vel_i      (lane_vel),
    .out_tready (out_tready),
    .out_tvalid (out_tvalid),
    .out_tdata  (out_tdata)
  );

`ifndef ASSERT_OFF
  // All lanes see the same command, so they must finish together.
  a_lockstep: assert property (@(posedge clk) disable iff (!rst_n)
    (&lane_done) == (|lane_done))
    else $error("joint lanes finished out of step");

  // Only one word is in flight at a time.
  a_one_word: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("second word taken while the first is in flight");

  // Lanes only report completion for a word that was taken.
  a_done_in_run: assert property (@(posedge clk) disable iff (!rst_n)
    all_done |-> (state_r == S_RUN))
    else $error("lane completion outside a running step");

  // A finished result only waits behind an older, unread one.
  a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_HOLD) |-> out_tvalid)
    else $error("result held back with the output register empty");
`endif

endmodule
